FILE: rtl/ssw_pkg.sv
// Shared constants, tables and control types for the supersaw oscillator.
`timescale 1ns / 1ps
package ssw_pkg;
    localparam int SAW_MAX        = 7;
    localparam int IDX_W          = 3;
    localparam int DEF_SAW_COUNT  = 7;
    localparam int DEF_PHASE_BITS = 24;

    localparam logic [23:0] STEP_MAX     = 24'd8053064;
    localparam logic [9:0]  DETUNE_RESET = 10'd819;
    localparam logic [35:0] U_DIVISOR    = 36'd1023;
    localparam logic [4:0]  DIV_B_STEPS  = 5'd16;
    localparam logic [15:0] RECIP_SIX    = 16'd43691;

    typedef struct packed {
        logic load_in;
        logic ld_ux;
        logic ld_uq;
        logic ld_u;
        logic ld_u2;
        logic ld_c1;
        logic ld_cube;
        logic ld_m;
        logic ld_prod;
        logic ld_step;
        logic b_start;
        logic ld_q;
        logic ld_sq;
        logic ld_term;
        logic ld_acc;
        logic ld_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic blep_act;
        logic last_saw;
    } t_sts;

    function automatic logic [24:0] k_of(input logic [IDX_W-1:0] idx);
        logic [24:0] k;
        case (idx)
            3'd1, 3'd2: k = 25'd27295313;
            3'd3, 3'd4: k = 25'd15600802;
            3'd5, 3'd6: k = 25'd4843542;
            default:    k = 25'd0;
        endcase
        return k;
    endfunction

    function automatic logic neg_of(input logic [IDX_W-1:0] idx);
        return (idx == 3'd1) || (idx == 3'd3) || (idx == 3'd5);
    endfunction

    function automatic logic [14:0] w_of(input logic [IDX_W-1:0] idx);
        logic [14:0] w;
        case (idx)
            3'd0:       w = 15'd14339;
            3'd5, 3'd6: w = 15'd5938;
            default:    w = 15'd9208;
        endcase
        return w;
    endfunction
endpackage

FILE: rtl/ssw_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ssw_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_rem_init,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_quot
);
    import ssw_pkg::*;

    logic [31:0] r_rem, n_rem;
    logic [15:0] r_quot, n_quot;
    logic [31:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_t;
    logic        w_ge;

    always_comb begin
        w_t    = {r_rem, 1'b0};
        w_ge   = w_t >= {1'b0, r_div};
        n_rem  = w_ge ? 32'(w_t - {1'b0, r_div}) : w_t[31:0];
        n_quot = {r_quot[14:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_B_STEPS;
                r_rem  <= i_rem_init;
                r_div  <= i_divisor;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                r_cnt  <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

FILE: rtl/ssw_datapath.sv
// Datapath: detuned step, polyBLEP saw, weighted mix and phase store.
`timescale 1ns / 1ps
module ssw_datapath #(
    parameter int SAW_COUNT  = ssw_pkg::DEF_SAW_COUNT,
    parameter int PHASE_BITS = ssw_pkg::DEF_PHASE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ssw_pkg::t_cmd i_cmd,
    output ssw_pkg::t_sts o_sts,
    input  logic [23:0]   i_base_step,
    input  logic          i_restart,
    input  logic [9:0]    i_detune_depth,
    output logic [15:0]   o_sample
);
    import ssw_pkg::*;

    localparam int IW = (SAW_COUNT > 1) ? $clog2(SAW_COUNT) : 1;
    localparam int SH = 32 - PHASE_BITS;

    logic [PHASE_BITS-1:0] r_phase [SAW_COUNT];
    logic [23:0]           r_base;
    logic [IDX_W-1:0]      r_idx;
    logic [34:0]           r_ux;
    logic [24:0]           r_uq;
    logic [24:0]           r_u;
    logic [49:0]           r_u2;
    logic [42:0]           r_c1;
    logic [10:0]           r_cube;
    logic [24:0]           r_m23;
    logic [48:0]           r_prod;
    logic [PHASE_BITS-1:0] r_step;
    logic                  r_bact;
    logic                  r_bhi;
    logic [15:0]           r_q;
    logic [31:0]           r_sq;
    logic signed [51:0]    r_term;
    logic signed [55:0]    r_acc;
    logic [15:0]           r_sample;

    logic [PHASE_BITS-1:0] w_p;
    logic [31:0]           w_p32, w_dt32;
    logic [32:0]           w_r;
    logic                  w_lo, w_hi;
    logic [35:0]           w_usum, w_urem;
    logic [33:0]           w_m32;
    logic [25:0]           w_s;
    logic [23:0]           w_s24;
    logic [55:0]           w_sx;
    logic [26:0]           w_c6;
    logic signed [35:0]    w_saw, w_blep, w_diff;
    logic signed [55:0]    w_rnd;
    logic signed [22:0]    w_res;
    logic                  div_start, div_done;
    logic [31:0]           div_rem, div_divisor;
    logic [15:0]           div_quot;

    always_comb begin
        w_p    = r_phase[r_idx[IW-1:0]];
        w_p32  = 32'(w_p) << SH;
        w_dt32 = 32'(r_step) << SH;
        w_r    = 33'h1_0000_0000 - {1'b0, w_p32};
        w_lo   = w_p32 < w_dt32;
        w_hi   = !w_lo && (w_r < {1'b0, w_dt32});
        // x/1023 estimate from x*(2^-10 + 2^-20 + 2^-30 + 2^-40), low by at most one
        w_usum = 36'(r_ux) + 36'(r_ux >> 10) + 36'(r_ux >> 20) + 36'(r_ux >> 30);
        w_urem = 36'(r_ux) + 36'(r_uq) - (36'(r_uq) << 10);
        w_c6   = 27'(r_c1[42:32] * RECIP_SIX);
        w_m32  = 34'h1_0000_0000 + 34'(r_u2[49:33]);
        if (neg_of(r_idx)) w_m32 = w_m32 - 34'(r_u) - 34'(r_cube);
        else               w_m32 = w_m32 + 34'(r_u) + 34'(r_cube);
        w_s    = 26'((r_prod + 49'h40_0000) >> 23);
        w_s24  = (w_s > 26'(STEP_MAX)) ? STEP_MAX : w_s[23:0];
        w_sx   = {32'd0, w_s24} << PHASE_BITS;
        w_saw  = 36'(signed'({1'b0, w_p32, 1'b0})) - 36'sh1_0000_0000;
        if (!r_bact)     w_blep = '0;
        else if (!r_bhi) w_blep = 36'(signed'({1'b0, r_q, 17'd0})) - 36'(signed'({1'b0, r_sq}))
                                  - 36'sh1_0000_0000;
        else             w_blep = 36'(signed'({1'b0, r_sq})) - 36'(signed'({1'b0, r_q, 17'd0}))
                                  + 36'sh1_0000_0000;
        w_diff = w_saw - w_blep;
        w_rnd  = r_acc + 56'sh1_0000_0000;
        w_res  = 23'(w_rnd >>> 33);
    end

    always_comb begin
        div_start   = i_cmd.b_start && (w_lo || w_hi);
        div_rem     = w_lo ? w_p32 : w_r[31:0];
        div_divisor = w_dt32;
    end

    ssw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_rem_init (div_rem),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SAW_COUNT; k++) r_phase[k] <= '0;
            r_idx <= '0;
        end else begin
            if (i_cmd.load_in) begin
                r_idx <= '0;
                if (i_restart) for (int k = 0; k < SAW_COUNT; k++) r_phase[k] <= '0;
            end
            if (i_cmd.ld_acc) begin
                r_phase[r_idx[IW-1:0]] <= w_p + r_step;
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_base <= i_base_step;
            r_acc  <= '0;
        end
        if (i_cmd.ld_ux)   r_ux   <= 35'(k_of(r_idx) * i_detune_depth) + 35'd511;
        if (i_cmd.ld_uq)   r_uq   <= 25'(w_usum >> 10);
        if (i_cmd.ld_u)    r_u    <= (w_urem >= U_DIVISOR) ? r_uq + 25'd1 : r_uq;
        if (i_cmd.ld_u2)   r_u2   <= r_u * r_u;
        if (i_cmd.ld_c1)   r_c1   <= r_u2[49:32] * r_u;
        if (i_cmd.ld_cube) r_cube <= 11'(w_c6 >> 18);
        if (i_cmd.ld_m)    r_m23  <= 25'((w_m32 + 34'd256) >> 9);
        if (i_cmd.ld_prod) r_prod <= r_base * r_m23;
        if (i_cmd.ld_step) r_step <= w_sx[24 +: PHASE_BITS];
        if (i_cmd.b_start) begin
            r_bact <= w_lo || w_hi;
            r_bhi  <= w_hi;
        end
        if (i_cmd.ld_q)    r_q    <= div_quot;
        if (i_cmd.ld_sq)   r_sq   <= r_q * r_q;
        if (i_cmd.ld_term) r_term <= 52'(w_diff * signed'({1'b0, w_of(r_idx)}));
        if (i_cmd.ld_acc)  r_acc  <= r_acc + 56'(r_term);
        if (i_cmd.ld_out) begin
            if (w_res > 23'sd32767)       r_sample <= 16'h7FFF;
            else if (w_res < -23'sd32768) r_sample <= 16'h8000;
            else                          r_sample <= w_res[15:0];
        end
    end

    assign o_sts.div_done = div_done;
    assign o_sts.blep_act = w_lo || w_hi;
    assign o_sts.last_saw = r_idx == IDX_W'(SAW_COUNT - 1);
    assign o_sample       = r_sample;
endmodule

FILE: rtl/ssw_ctrl.sv
// Sequencer: steps each saw through step, polyBLEP and mix, then hands off the sample.
`timescale 1ns / 1ps
module ssw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ssw_pkg::t_cmd o_cmd,
    input  ssw_pkg::t_sts i_sts
);
    import ssw_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UPROD  = 4'd1;
    localparam logic [3:0] S_UEST   = 4'd2;
    localparam logic [3:0] S_UFIX   = 4'd3;
    localparam logic [3:0] S_SQ     = 4'd4;
    localparam logic [3:0] S_CUBE   = 4'd5;
    localparam logic [3:0] S_DIV6   = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_PROD   = 4'd8;
    localparam logic [3:0] S_STEP   = 4'd9;
    localparam logic [3:0] S_BSTART = 4'd10;
    localparam logic [3:0] S_BWAIT  = 4'd11;
    localparam logic [3:0] S_BSQ    = 4'd12;
    localparam logic [3:0] S_MIX    = 4'd13;
    localparam logic [3:0] S_ACC    = 4'd14;
    localparam logic [3:0] S_FIN    = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_UPROD;
                end
            end
            S_UPROD: begin
                o_cmd.ld_ux = 1'b1;
                n_state     = S_UEST;
            end
            S_UEST: begin
                o_cmd.ld_uq = 1'b1;
                n_state     = S_UFIX;
            end
            S_UFIX: begin
                o_cmd.ld_u = 1'b1;
                n_state    = S_SQ;
            end
            S_SQ: begin
                o_cmd.ld_u2 = 1'b1;
                n_state     = S_CUBE;
            end
            S_CUBE: begin
                o_cmd.ld_c1 = 1'b1;
                n_state     = S_DIV6;
            end
            S_DIV6: begin
                o_cmd.ld_cube = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_cmd.ld_m = 1'b1;
                n_state    = S_PROD;
            end
            S_PROD: begin
                o_cmd.ld_prod = 1'b1;
                n_state       = S_STEP;
            end
            S_STEP: begin
                o_cmd.ld_step = 1'b1;
                n_state       = S_BSTART;
            end
            S_BSTART: begin
                o_cmd.b_start = 1'b1;
                n_state       = i_sts.blep_act ? S_BWAIT : S_MIX;
            end
            S_BWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_q = 1'b1;
                    n_state    = S_BSQ;
                end
            end
            S_BSQ: begin
                o_cmd.ld_sq = 1'b1;
                n_state     = S_MIX;
            end
            S_MIX: begin
                o_cmd.ld_term = 1'b1;
                n_state       = S_ACC;
            end
            S_ACC: begin
                o_cmd.ld_acc = 1'b1;
                n_state      = i_sts.last_saw ? S_FIN : S_UPROD;
            end
            S_FIN: begin
                if (!n_out_valid) begin
                    o_cmd.ld_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
endmodule

FILE: rtl/supersaw_oscillator_unit.sv
// Top level of the supersaw oscillator: config register, sequencer and datapath.
//
// Input channel (i_in_valid / o_in_stall) carries one request per output
// sample: i_base_step (Q0.24 phase step) and i_restart (clear all phases first).
// Output channel (o_out_valid / i_out_stall) carries o_sample, signed Q1.15.
// A request is taken when valid is high and stall is low.
// Each saw goes through its detune exponent (multiply, reciprocal estimate,
// correction), its step (square, cube, divide by six, sum, product, step),
// a polyBLEP test, an optional 16-step serial polyBLEP divide with its
// squaring, and the mix (weighted term, accumulate). The next request can be
// taken in the same cycle in which o_out_valid rises. The input stalls while
// a sample is in work; a finished sample sits in the output register, so the
// next request is taken while it waits. If the receiver still stalls when the
// next sample is done, the sequencer holds.
// Reset (i_rst_n low, synchronous) clears all phases, sets the detune depth to
// 819 and empties the output register. The user writes the detune depth over
// APB at byte address 0 only while idle; the block does not enforce this.
`timescale 1ns / 1ps
module supersaw_oscillator_unit #(
    parameter int SAW_COUNT  = ssw_pkg::DEF_SAW_COUNT,
    parameter int PHASE_BITS = ssw_pkg::DEF_PHASE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [23:0] i_base_step,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [15:0] o_sample
);
    import ssw_pkg::*;

    logic [9:0]  r_detune_depth;
    t_cmd        cmd;
    t_sts        sts;
    logic [15:0] sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detune_depth <= DETUNE_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_detune_depth <= pwdata[9:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {22'd0, r_detune_depth};

    ssw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ssw_datapath #(
        .SAW_COUNT  (SAW_COUNT),
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_base_step    (i_base_step),
        .i_restart      (i_restart),
        .i_detune_depth (r_detune_depth),
        .o_sample       (sample)
    );

    assign o_sample = signed'(sample);
endmodule

FILE: bench/supersaw_checker.sv
// Supersaw oscillator checker: watches config writes and both channels, predicts samples.
`timescale 1ns / 1ps
module supersaw_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               i_in_valid,
    input  logic               o_in_stall,
    input  logic [23:0]        i_base_step,
    input  logic               i_restart,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] o_sample,
    output int                 o_errors,
    output int                 o_pending
);
    localparam int N_SAW = 7;
    localparam logic [2:0] REG_DETUNE = 3'd0;

    logic [63:0] osc_k [N_SAW] = '{64'd0, 64'd27295313, 64'd27295313, 64'd15600802,
                                   64'd15600802, 64'd4843542, 64'd4843542};
    bit          osc_down [N_SAW] = '{0, 1, 0, 1, 0, 1, 0};
    logic [63:0] osc_mix [N_SAW] = '{64'd14339, 64'd9208, 64'd9208, 64'd9208,
                                     64'd9208, 64'd5938, 64'd5938};

    logic [23:0]        phase_acc [N_SAW];
    logic [9:0]         detune;
    logic signed [15:0] sample_q [$];
    int                 n_in;

    function automatic logic [23:0] detuned_step(int idx, logic [23:0] base);
        logic [63:0] u, u2, cube, m, s;
        u    = (osc_k[idx] * detune + 64'd511) / 64'd1023;
        u2   = u * u;
        cube = (((u2 >> 32) * u) >> 32) / 64'd6;
        m    = (64'd1 << 32) + (u2 >> 33);
        m    = osc_down[idx] ? m - u - cube : m + u + cube;
        m    = (m + 64'd256) >> 9;
        s    = ({40'd0, base} * m + (64'd1 << 22)) >> 23;
        if (s > ssw_pkg::STEP_MAX) s = ssw_pkg::STEP_MAX;
        return s[23:0];
    endfunction

    function automatic logic signed [63:0] blep_fix(logic [63:0] p, logic [63:0] dt);
        logic signed [63:0] q;
        if (p < dt) begin
            q = (p << 16) / dt;
            return (q << 17) - q * q - (64'sd1 <<< 32);
        end
        if ((64'd1 << 32) - p < dt) begin
            q = (((64'd1 << 32) - p) << 16) / dt;
            return q * q - (q << 17) + (64'sd1 <<< 32);
        end
        return 0;
    endfunction

    function automatic logic signed [15:0] next_sample(logic [23:0] base, logic rst);
        logic signed [63:0] acc, saw, res;
        logic [63:0]        p32, dt32, sum;
        logic [23:0]        st;
        acc = 0;
        for (int i = 0; i < N_SAW; i++) begin
            if (rst) phase_acc[i] = '0;
            st   = detuned_step(i, base);
            p32  = {32'd0, phase_acc[i], 8'd0};
            dt32 = {32'd0, st, 8'd0};
            saw  = $signed(p32 * 2) - (64'sd1 <<< 32);
            saw  = saw - blep_fix(p32, dt32);
            acc  = acc + saw * $signed(osc_mix[i]);
            phase_acc[i] = phase_acc[i] + st;
        end
        sum = acc + (64'sd1 <<< 32) + (64'sd1 <<< 55);
        res = $signed(sum >> 33) - (64'sd1 <<< 22);
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        return res[15:0];
    endfunction

    task automatic report(string what, logic signed [15:0] got, logic signed [15:0] want);
        $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    assign o_pending = sample_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_SAW; i++) phase_acc[i] <= '0;
            detune   <= ssw_pkg::DETUNE_RESET;
            o_errors <= 0;
            sample_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_DETUNE[0])
                detune <= pwdata[9:0];
            if (i_in_valid && !o_in_stall)
                sample_q.push_back(next_sample(i_base_step, i_restart));
            if (o_out_valid && !i_out_stall) begin
                if (sample_q.size() == 0)
                    report("unexpected sample", o_sample, 16'sd0);
                else if (o_sample !== sample_q[0])
                    report("sample", o_sample, sample_q.pop_front());
                else
                    void'(sample_q.pop_front());
            end
        end
    end
endmodule

FILE: bench/testbench.sv
// Supersaw oscillator testbench top: clock, reset, stimulus, config writes and verdict.
`timescale 1ns / 1ps
module testbench;
    localparam int WATCHDOG = 6000;
    localparam logic [2:0] ADDR_DETUNE = 3'd0;

    logic        i_clk = 0, i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic        pready;
    logic        i_in_valid = 0, o_in_stall;
    logic [23:0] i_base_step = '0;
    logic        i_restart = 0;
    logic        o_out_valid, i_out_stall = 0;
    logic signed [15:0] o_sample;
    int          errors, pending;
    int          idle_cycles = 0;
    bit          no_gaps;

    always #1 i_clk = ~i_clk;

    supersaw_oscillator_unit u_dut (.*);

    supersaw_checker u_chk (.*, .o_errors(errors), .o_pending(pending));

    task automatic write_detune(logic [9:0] val);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= ADDR_DETUNE; pwdata <= {22'd0, val};
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_request(logic [23:0] base, logic rst);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1;
        i_base_step <= base;
        i_restart   <= rst;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain;
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_burst(int n);
        logic [23:0] b;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0:       b = 24'($urandom_range(0, 8388608));
                1:       b = $urandom_range(0, 1) ? 24'd0 : 24'h800000;
                2:       b = 24'($urandom_range(0, 32));
                default: b = 24'($urandom_range(0, 200000));
            endcase
            send_request(b, $urandom_range(0, 19) == 0);
        end
    endtask

    // receiver stalls
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = no_gaps ? 0 : $urandom_range(0, 14);
            if (n > 0) begin
                i_out_stall <= 1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        no_gaps = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: zero and small steps, restart, steps near and at one half
        send_request(24'd0, 1'b1);
        send_request(24'd0, 1'b0);
        send_request(24'h7FFFFF, 1'b0);
        send_request(24'h800000, 1'b0);
        send_request(24'h800000, 1'b1);
        send_request(24'd1, 1'b1);
        send_request(24'd1, 1'b0);
        send_request(24'd16000000 >> 1, 1'b0);
        send_request(24'd50000, 1'b1);
        repeat (6) send_request(24'd50000, 1'b0);
        send_request(24'd3000000, 1'b0);
        send_request(24'd4194304, 1'b0);
        drain();

        write_detune(10'd0);
        send_request(24'd100000, 1'b1);
        random_burst(150);
        drain();

        write_detune(10'd1023);
        send_request(24'h7FFFFF, 1'b1);
        random_burst(200);
        drain();

        no_gaps = 1;
        write_detune(10'd1);
        random_burst(100);
        drain();
        no_gaps = 0;

        for (int ph = 0; ph < 4; ph++) begin
            write_detune(10'($urandom_range(0, 1023)));
            random_burst(110);
            drain();
        end

        repeat (500) @(posedge i_clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

FILE: sim.f
rtl/ssw_pkg.sv
rtl/ssw_div.sv
rtl/ssw_datapath.sv
rtl/ssw_ctrl.sv
rtl/supersaw_oscillator_unit.sv
bench/supersaw_checker.sv
bench/testbench.sv
